FILE: hdl/plc_pkg.sv
// Shared types and constants for the password lock controller.
// No dependencies.
package plc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int ADDR_W      = 11;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 40;

    localparam logic [CFG_INDEX_W-1:0] REG_OPEN_TICKS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_TICKS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_TICKS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STORE_BASE  = 3'd4;

    localparam logic [7:0] CMD_SET_A    = 8'h2D;
    localparam logic [7:0] CMD_SET_B    = 8'h02;
    localparam logic [7:0] CMD_VERIFY   = 8'h03;
    localparam logic [7:0] CMD_OPEN     = 8'h2B;
    localparam logic [7:0] CMD_ALARM    = 8'h20;
    localparam logic [7:0] REPLY_MATCH  = 8'hF1;
    localparam logic [7:0] REPLY_DIFFER = 8'hFF;

    localparam logic [1:0] MOTOR_STOP = 2'd0;
    localparam logic [1:0] MOTOR_CW   = 2'd1;
    localparam logic [1:0] MOTOR_CCW  = 2'd2;

    localparam logic [7:0]        OPEN_TICKS_RST  = 8'd15;
    localparam logic [7:0]        HOLD_TICKS_RST  = 8'd3;
    localparam logic [7:0]        CLOSE_TICKS_RST = 8'd15;
    localparam logic [7:0]        ALARM_TICKS_RST = 8'd60;
    localparam logic [ADDR_W-1:0] STORE_BASE_RST  = 11'h050;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } kind_t;

    typedef struct packed {
        logic [7:0]        open_ticks;
        logic [7:0]        hold_ticks;
        logic [7:0]        close_ticks;
        logic [7:0]        alarm_ticks;
        logic [ADDR_W-1:0] store_base;
    } cfg_t;

    typedef struct packed {
        logic              reply_valid;
        logic [7:0]        reply_byte;
        logic [1:0]        motor_dir;
        logic              alarm_on;
        logic              mem_write;
        logic [ADDR_W-1:0] mem_address;
        logic [7:0]        mem_data;
        logic              dropped;
    } result_t;

endpackage

FILE: hdl/password_lock_controller.sv
// Password lock controller top level: input register, sequencer, result register.
// Item path: input register, then result register; one item per cycle unless m_tready is low.
// The single-pass sequencer between the two registers sets the rate.
// Reset: synchronous active-low aresetn; password store clears to zeros, config
// registers return to defaults. Depends on plc_pkg, plc_cfg_regs, plc_ctrl.
module password_lock_controller
    import plc_pkg::*;
#(
    parameter int PASSWORD_LENGTH = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [7:0] byte_value
    input  logic                   s_tuser,   // [0] kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] reply_valid, [8:1] reply_byte, [10:9] motor_dir, [11] alarm_on,
    // [12] mem_write, [23:13] mem_address, [31:24] mem_data, [32] dropped
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t       cfg;
    result_t    result;
    result_t    out_reg;
    logic       in_valid_reg;
    kind_t      in_kind_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= kind_t'(s_tuser);
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    plc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    plc_ctrl #(
        .PASSWORD_LENGTH (PASSWORD_LENGTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_en    (advance),
        .kind       (in_kind_reg),
        .byte_value (in_byte_reg),
        .cfg        (cfg),
        .result     (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.dropped, out_reg.mem_data, out_reg.mem_address,
                       out_reg.mem_write, out_reg.alarm_on, out_reg.motor_dir,
                       out_reg.reply_byte, out_reg.reply_valid};

endmodule

FILE: hdl/plc_cfg_regs.sv
// Configuration register bank: tick durations and password store base.
// Depends on plc_pkg.
module plc_cfg_regs
    import plc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.open_ticks  <= OPEN_TICKS_RST;
            cfg_reg.hold_ticks  <= HOLD_TICKS_RST;
            cfg_reg.close_ticks <= CLOSE_TICKS_RST;
            cfg_reg.alarm_ticks <= ALARM_TICKS_RST;
            cfg_reg.store_base  <= STORE_BASE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_OPEN_TICKS:  cfg_reg.open_ticks  <= cfg_data[7:0];
                REG_HOLD_TICKS:  cfg_reg.hold_ticks  <= cfg_data[7:0];
                REG_CLOSE_TICKS: cfg_reg.close_ticks <= cfg_data[7:0];
                REG_ALARM_TICKS: cfg_reg.alarm_ticks <= cfg_data[7:0];
                REG_STORE_BASE:  cfg_reg.store_base  <= cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/plc_ctrl.sv
// Command sequencer: password entry and compare, motor and buzzer timing.
// Computes one result per item in a single pass. Depends on plc_pkg.
module plc_ctrl
    import plc_pkg::*;
#(
    parameter int PASSWORD_LENGTH = 5
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_en,
    input  kind_t      kind,
    input  logic [7:0] byte_value,
    input  cfg_t       cfg,
    output result_t    result
);

    localparam int IDX_W = (PASSWORD_LENGTH > 1) ? $clog2(PASSWORD_LENGTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PASSWORD_LENGTH - 1);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_FIRST,
        MODE_SECOND,
        MODE_VERIFY,
        MODE_OPEN,
        MODE_HOLD,
        MODE_CLOSE,
        MODE_ALARM
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             mismatch_reg, mismatch_next;
    logic [7:0]       tick_reg, tick_next;
    logic [7:0]       first_entry [PASSWORD_LENGTH];
    logic [7:0]       stored_pw_reg [PASSWORD_LENGTH];

    logic             last_byte;
    logic             first_we;
    logic             commit_pw;
    logic [7:0]       limit;
    logic             timing;
    logic [7:0]       tick_inc;
    logic             miss_first;
    logic             miss_stored;

    assign last_byte   = (idx_reg == LAST_IDX);
    assign tick_inc    = tick_reg + 8'd1;
    assign miss_first  = (first_entry[idx_reg] != byte_value);
    assign miss_stored = (stored_pw_reg[idx_reg] != byte_value);

    always_comb begin
        unique case (mode_reg)
            MODE_OPEN:  limit = cfg.open_ticks;
            MODE_HOLD:  limit = cfg.hold_ticks;
            MODE_CLOSE: limit = cfg.close_ticks;
            MODE_ALARM: limit = cfg.alarm_ticks;
            default:    limit = 8'd0;
        endcase
        timing = (mode_reg == MODE_OPEN) || (mode_reg == MODE_HOLD) ||
                 (mode_reg == MODE_CLOSE) || (mode_reg == MODE_ALARM);
    end

    always_comb begin
        mode_next     = mode_reg;
        idx_next      = idx_reg;
        mismatch_next = mismatch_reg;
        tick_next     = tick_reg;
        first_we      = 1'b0;
        commit_pw     = 1'b0;
        result        = '0;

        if (kind == KIND_BYTE) begin
            unique case (mode_reg)
                MODE_IDLE: begin
                    priority if (byte_value == CMD_SET_A || byte_value == CMD_SET_B) begin
                        mode_next     = MODE_FIRST;
                        idx_next      = '0;
                        mismatch_next = 1'b0;
                    end else if (byte_value == CMD_VERIFY) begin
                        mode_next     = MODE_VERIFY;
                        idx_next      = '0;
                        mismatch_next = 1'b0;
                    end else if (byte_value == CMD_OPEN) begin
                        mode_next = MODE_OPEN;
                        tick_next = 8'd0;
                    end else if (byte_value == CMD_ALARM) begin
                        mode_next = MODE_ALARM;
                        tick_next = 8'd0;
                    end else begin
                    end
                end
                MODE_FIRST: begin
                    first_we           = 1'b1;
                    result.mem_write   = 1'b1;
                    result.mem_address = cfg.store_base + ADDR_W'(idx_reg);
                    result.mem_data    = byte_value;
                    if (last_byte) begin
                        mode_next = MODE_SECOND;
                        idx_next  = '0;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                MODE_SECOND: begin
                    result.mem_write   = 1'b1;
                    result.mem_address = cfg.store_base + ADDR_W'(idx_reg);
                    result.mem_data    = byte_value;
                    mismatch_next      = mismatch_reg | miss_first;
                    if (last_byte) begin
                        result.reply_valid = 1'b1;
                        result.reply_byte  = mismatch_next ? REPLY_DIFFER : REPLY_MATCH;
                        commit_pw          = !mismatch_next;
                        mode_next          = MODE_IDLE;
                        idx_next           = '0;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                MODE_VERIFY: begin
                    mismatch_next = mismatch_reg | miss_stored;
                    if (last_byte) begin
                        result.reply_valid = 1'b1;
                        result.reply_byte  = mismatch_next ? REPLY_DIFFER : REPLY_MATCH;
                        mode_next          = MODE_IDLE;
                        idx_next           = '0;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                default: result.dropped = 1'b1;
            endcase
        end else if (timing) begin
            tick_next = tick_inc;
            if (tick_inc == limit) begin
                tick_next = 8'd0;
                priority if (mode_reg == MODE_OPEN) begin
                    mode_next = MODE_HOLD;
                end else if (mode_reg == MODE_HOLD) begin
                    mode_next = MODE_CLOSE;
                end else begin
                    mode_next = MODE_IDLE;
                end
            end
        end

        result.motor_dir = (mode_next == MODE_OPEN)  ? MOTOR_CW :
                           (mode_next == MODE_CLOSE) ? MOTOR_CCW : MOTOR_STOP;
        result.alarm_on  = (mode_next == MODE_ALARM);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            idx_reg      <= '0;
            mismatch_reg <= 1'b0;
            tick_reg     <= 8'd0;
            for (int i = 0; i < PASSWORD_LENGTH; i++) begin
                stored_pw_reg[i] <= 8'd0;
            end
        end else if (item_en) begin
            mode_reg     <= mode_next;
            idx_reg      <= idx_next;
            mismatch_reg <= mismatch_next;
            tick_reg     <= tick_next;
            if (commit_pw) begin
                for (int i = 0; i < PASSWORD_LENGTH; i++) begin
                    stored_pw_reg[i] <= first_entry[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_en && first_we) begin
            first_entry[idx_reg] <= byte_value;
        end
    end

endmodule

FILE: hdl/plc_checker.sv
// Port-level checks for the password lock controller, bound to the top level.
// Depends on plc_pkg.
module plc_checker
    import plc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic       reply_valid;
    logic [7:0] reply_byte;
    logic [1:0] motor_dir;
    logic       alarm_on;
    logic       mem_write;
    logic       dropped;

    assign reply_valid = m_tdata[0];
    assign reply_byte  = m_tdata[8:1];
    assign motor_dir   = m_tdata[10:9];
    assign alarm_on    = m_tdata[11];
    assign mem_write   = m_tdata[12];
    assign dropped     = m_tdata[32];

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reply_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && reply_valid |-> reply_byte == REPLY_MATCH || reply_byte == REPLY_DIFFER)
        else $error("bad reply code");

    a_motor_buzzer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> motor_dir != 2'b11 && !(alarm_on && motor_dir != MOTOR_STOP))
        else $error("motor and buzzer active together");

    a_dropped_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && dropped |-> !mem_write && !reply_valid && reply_byte == 8'd0)
        else $error("dropped item produced a write or reply");

endmodule

bind password_lock_controller plc_checker u_plc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/tb_password_lock_controller.sv
// Self-checking testbench for password_lock_controller: a queue-fed stream driver, a
// result monitor and an in-bench predictor of the lock sequencer with its own state.
// Depends on plc_pkg and the password_lock_controller RTL.
module tb_password_lock_controller;
    import plc_pkg::*;

    localparam int PW_LEN     = 5;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [2:0] {
        LK_IDLE, LK_FIRST, LK_SECOND, LK_VERIFY, LK_OPEN, LK_HOLD, LK_CLOSE, LK_ALARM
    } lock_mode_t;

    typedef struct {
        kind_t      kind;
        logic [7:0] value;
    } lock_item_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // [7:0] byte_value
    logic                   s_tuser   = 1'b0; // [0] kind
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // [0] reply_valid, [8:1] reply_byte, [10:9] motor_dir, [11] alarm_on,
    // [12] mem_write, [23:13] mem_address, [31:24] mem_data, [32] dropped
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    password_lock_controller #(.PASSWORD_LENGTH(PW_LEN)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    cfg_t       lk_cfg = '{OPEN_TICKS_RST, HOLD_TICKS_RST, CLOSE_TICKS_RST,
                           ALARM_TICKS_RST, STORE_BASE_RST};
    lock_mode_t lk_mode  = LK_IDLE;
    int         lk_index = 0;
    logic [7:0] lk_first  [PW_LEN];
    logic [7:0] lk_stored [PW_LEN];
    logic       lk_miss  = 1'b0;
    logic [7:0] lk_ticks = 8'd0;

    lock_item_t pending_q[$];
    result_t    lock_expect_q[$];
    int         errors = 0;
    int         cyc = 0;
    int         results_seen = 0;
    int         stall_left = 0;
    bit         long_stall_done = 1'b0;
    int         items_pushed = 0;
    logic [PW_LEN*8-1:0] gen_pw = '0;

    initial begin
        foreach (lk_stored[i]) begin
            lk_stored[i] = 8'd0;
            lk_first[i]  = 8'd0;
        end
    end

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic result_t predict_lock(kind_t k, logic [7:0] b);
        result_t    r;
        logic [7:0] limit;
        bit         timing;
        int         pos;
        r = '0;
        pos = lk_index % PW_LEN;
        if (k == KIND_BYTE) begin
            case (lk_mode)
                LK_IDLE: begin
                    if (b == CMD_SET_A || b == CMD_SET_B) begin
                        lk_mode = LK_FIRST; lk_index = 0; lk_miss = 1'b0;
                    end else if (b == CMD_VERIFY) begin
                        lk_mode = LK_VERIFY; lk_index = 0; lk_miss = 1'b0;
                    end else if (b == CMD_OPEN) begin
                        lk_mode = LK_OPEN; lk_ticks = 8'd0;
                    end else if (b == CMD_ALARM) begin
                        lk_mode = LK_ALARM; lk_ticks = 8'd0;
                    end
                end
                LK_FIRST: begin
                    lk_first[pos] = b;
                    r.mem_write = 1'b1;
                    r.mem_address = ADDR_W'(lk_cfg.store_base + pos);
                    r.mem_data = b;
                    if (lk_index + 1 >= PW_LEN) begin
                        lk_mode = LK_SECOND; lk_index = 0;
                    end else lk_index++;
                end
                LK_SECOND: begin
                    r.mem_write = 1'b1;
                    r.mem_address = ADDR_W'(lk_cfg.store_base + pos);
                    r.mem_data = b;
                    if (lk_first[pos] != b) lk_miss = 1'b1;
                    if (lk_index + 1 >= PW_LEN) begin
                        r.reply_valid = 1'b1;
                        if (lk_miss) r.reply_byte = REPLY_DIFFER;
                        else begin
                            r.reply_byte = REPLY_MATCH;
                            foreach (lk_stored[i]) lk_stored[i] = lk_first[i];
                        end
                        lk_mode = LK_IDLE; lk_index = 0;
                    end else lk_index++;
                end
                LK_VERIFY: begin
                    if (lk_stored[pos] != b) lk_miss = 1'b1;
                    if (lk_index + 1 >= PW_LEN) begin
                        r.reply_valid = 1'b1;
                        r.reply_byte = lk_miss ? REPLY_DIFFER : REPLY_MATCH;
                        lk_mode = LK_IDLE; lk_index = 0;
                    end else lk_index++;
                end
                default: r.dropped = 1'b1;
            endcase
        end else begin
            timing = 1'b1;
            case (lk_mode)
                LK_OPEN:  limit = lk_cfg.open_ticks;
                LK_HOLD:  limit = lk_cfg.hold_ticks;
                LK_CLOSE: limit = lk_cfg.close_ticks;
                LK_ALARM: limit = lk_cfg.alarm_ticks;
                default: begin
                    limit = 8'd0;
                    timing = 1'b0;
                end
            endcase
            if (timing) begin
                lk_ticks = lk_ticks + 8'd1;
                if (lk_ticks == limit) begin
                    lk_ticks = 8'd0;
                    if (lk_mode == LK_OPEN) lk_mode = LK_HOLD;
                    else if (lk_mode == LK_HOLD) lk_mode = LK_CLOSE;
                    else lk_mode = LK_IDLE;
                end
            end
        end
        r.motor_dir = (lk_mode == LK_OPEN) ? MOTOR_CW :
                      (lk_mode == LK_CLOSE) ? MOTOR_CCW : MOTOR_STOP;
        r.alarm_on  = (lk_mode == LK_ALARM);
        return r;
    endfunction

    function automatic bit calm();
        return cyc >= 1000 && cyc < 1600;
    endfunction

    // driver
    always @(posedge aclk) begin : drive
        lock_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                lock_expect_q.push_back(predict_lock(kind_t'(s_tuser), s_tdata));
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() > 0 && (calm() || $urandom_range(0, 99) >= 30)) begin
                    nxt = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.kind;
                    s_tdata  <= nxt.value;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : watch
        result_t want;
        result_t got;
        bit      rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.reply_valid = m_tdata[0];
                got.reply_byte  = m_tdata[8:1];
                got.motor_dir   = m_tdata[10:9];
                got.alarm_on    = m_tdata[11];
                got.mem_write   = m_tdata[12];
                got.mem_address = m_tdata[23:13];
                got.mem_data    = m_tdata[31:24];
                got.dropped     = m_tdata[32];
                if (lock_expect_q.size() == 0) begin
                    $display("%0t: unexpected result item, expected none, actual 0x%0h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = lock_expect_q.pop_front();
                    if (want != got) begin
                        $display("%0t: result mismatch, expected 0x%0h, actual 0x%0h",
                                 $time, want, got);
                        errors++;
                    end
                end
                results_seen++;
            end
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (!long_stall_done && results_seen >= 400) begin
                // long back-pressure so the input side fills and stalls
                long_stall_done = 1'b1;
                stall_left = 250;
                rdy = 1'b0;
            end else begin
                rdy = calm() || $urandom_range(0, 99) >= 30;
            end
            m_tready <= rdy;
        end
    end

    always @(posedge aclk) begin
        cyc++;
        if (cyc >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stimulus generation
    task automatic push_item(kind_t k, logic [7:0] v, bit counts);
        lock_item_t it;
        it.kind = k;
        it.value = v;
        pending_q.push_back(it);
        if (counts) items_pushed++;
    endtask

    task automatic push_entry(logic [PW_LEN*8-1:0] e);
        for (int i = 0; i < PW_LEN; i++) begin
            if ($urandom_range(0, 99) < 10) push_item(KIND_TICK, 8'($urandom), 1'b0);
            push_item(KIND_BYTE, e[i*8 +: 8], 1'b1);
        end
    endtask

    function automatic logic [PW_LEN*8-1:0] spoil(logic [PW_LEN*8-1:0] e);
        int p;
        p = $urandom_range(0, PW_LEN - 1);
        e[p*8 +: 8] = e[p*8 +: 8] ^ 8'($urandom_range(1, 255));
        return e;
    endfunction

    function automatic logic [PW_LEN*8-1:0] random_entry();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[PW_LEN*8-1:0];
    endfunction

    function automatic int ticks_for(logic [7:0] l);
        return (l == 8'd0) ? 256 : int'(l);
    endfunction

    task automatic gen_set(bit match);
        logic [PW_LEN*8-1:0] e;
        e = random_entry();
        push_item(KIND_BYTE, $urandom_range(0, 1) ? CMD_SET_A : CMD_SET_B, 1'b1);
        push_entry(e);
        push_entry(match ? e : spoil(e));
        if (match) gen_pw = e;
    endtask

    task automatic gen_verify(bit right);
        push_item(KIND_BYTE, CMD_VERIFY, 1'b1);
        push_entry(right ? gen_pw : spoil(gen_pw));
    endtask

    task automatic gen_timed(bit do_open);
        int total;
        if (do_open) begin
            push_item(KIND_BYTE, CMD_OPEN, 1'b1);
            total = ticks_for(lk_cfg.open_ticks) + ticks_for(lk_cfg.hold_ticks)
                  + ticks_for(lk_cfg.close_ticks);
        end else begin
            push_item(KIND_BYTE, CMD_ALARM, 1'b1);
            total = ticks_for(lk_cfg.alarm_ticks);
        end
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(0, 99) < 15) push_item(KIND_BYTE, 8'($urandom), 1'b1);
            push_item(KIND_TICK, 8'($urandom), 1'b1);
        end
    endtask

    task automatic gen_broken();
        int n;
        n = $urandom_range(1, PW_LEN - 1);
        push_item(KIND_BYTE, $urandom_range(0, 1) ? CMD_VERIFY : CMD_SET_B, 1'b1);
        for (int i = 0; i < n; i++) push_item(KIND_BYTE, 8'($urandom), 1'b1);
    endtask

    task automatic run_random(int budget);
        int start;
        int pick;
        start = items_pushed;
        while (items_pushed - start < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) gen_set(1'b1);
            else if (pick < 30) gen_set(1'b0);
            else if (pick < 50) gen_verify(1'b1);
            else if (pick < 65) gen_verify(1'b0);
            else if (pick < 74) gen_timed(1'b1);
            else if (pick < 83) gen_timed(1'b0);
            else if (pick < 95) begin
                if ($urandom_range(0, 1)) push_item(KIND_TICK, 8'($urandom), 1'b0);
                else push_item(KIND_BYTE, 8'($urandom), 1'b1);
            end else gen_broken();
        end
    endtask

    task automatic wait_drain();
        while (pending_q.size() != 0 || s_tvalid || lock_expect_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(v);
        @(posedge aclk);
    endtask

    task automatic set_config(int unsigned op, int unsigned hd, int unsigned cl,
                              int unsigned al, int unsigned base);
        wait_drain();
        repeat (4) @(posedge aclk);
        write_reg(REG_OPEN_TICKS, op);
        write_reg(REG_HOLD_TICKS, hd);
        write_reg(REG_CLOSE_TICKS, cl);
        write_reg(REG_ALARM_TICKS, al);
        write_reg(REG_STORE_BASE, base);
        cfg_we <= 1'b0;
        lk_cfg.open_ticks  = 8'(op);
        lk_cfg.hold_ticks  = 8'(hd);
        lk_cfg.close_ticks = 8'(cl);
        lk_cfg.alarm_ticks = 8'(al);
        lk_cfg.store_base  = ADDR_W'(base);
        @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: idle tick, unknown command, verify against cleared store, set
        push_item(KIND_TICK, 8'hFF, 1'b0);
        push_item(KIND_BYTE, 8'h55, 1'b0);
        push_item(KIND_BYTE, CMD_VERIFY, 1'b1);
        push_entry('0);
        push_item(KIND_BYTE, CMD_VERIFY, 1'b1);
        push_entry({8'h01, 32'h0});
        push_item(KIND_BYTE, CMD_SET_A, 1'b1);
        push_entry(40'h01_7F_80_FF_00);
        push_entry(40'h01_7F_80_FF_00);
        gen_pw = 40'h01_7F_80_FF_00;
        run_random(140);

        set_config(1, 1, 1, 1, 0);
        run_random(140);

        // zero hold count runs the full 8-bit wrap; base near the top wraps addresses
        set_config(1, 0, 1, 1, 2044);
        gen_set(1'b1);
        gen_verify(1'b1);
        gen_timed(1'b1);

        set_config($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
                   $urandom_range(1, 6), $urandom_range(0, 2047));
        run_random(140);

        wait_drain();
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
